### design/fixed_point_alu_q24_8_defines.svh
// Assertion macros shared by the checker of the fixed-point ALU.
// Depends on nothing; included by the checker file.
`ifndef FIXED_POINT_ALU_Q24_8_DEFINES_SVH
`define FIXED_POINT_ALU_Q24_8_DEFINES_SVH

// Checked at every clock edge outside reset.
`define FPA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fpa check failed");

// Checked at every clock edge, reset included.
`define FPA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fpa check failed");

`endif

### design/fpa_pkg.sv
// Types and constants of the fixed-point ALU.
// Used by every module of the block; depends on nothing.
package fpa_pkg;

  localparam logic [4:0] OP_ADD      = 5'd0;
  localparam logic [4:0] OP_SUB      = 5'd1;
  localparam logic [4:0] OP_MUL      = 5'd2;
  localparam logic [4:0] OP_DIV      = 5'd3;
  localparam logic [4:0] OP_LT       = 5'd4;
  localparam logic [4:0] OP_GT       = 5'd5;
  localparam logic [4:0] OP_LE       = 5'd6;
  localparam logic [4:0] OP_GE       = 5'd7;
  localparam logic [4:0] OP_EQ       = 5'd8;
  localparam logic [4:0] OP_NE       = 5'd9;
  localparam logic [4:0] OP_MIN      = 5'd10;
  localparam logic [4:0] OP_MAX      = 5'd11;
  localparam logic [4:0] OP_ABS      = 5'd12;
  localparam logic [4:0] OP_INC      = 5'd13;
  localparam logic [4:0] OP_DEC      = 5'd14;
  localparam logic [4:0] OP_FROM_INT = 5'd15;
  localparam logic [4:0] OP_TO_INT   = 5'd16;

  localparam logic signed [31:0] RAW_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] RAW_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    CLS_FAST,
    CLS_MUL,
    CLS_DIV
  } op_class_t;

  typedef struct packed {
    logic [4:0]         opcode;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               overflow;
    logic               divide_by_zero;
  } out_item_t;

  typedef struct packed {
    op_class_t   cls;
    out_item_t   fast;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        neg;
  } entry_t;

endpackage

### design/fpa_front.sv
// Front end: decodes an item, computes the fast-class operations and
// prepares magnitudes for multiply and divide. Depends on fpa_pkg.
module fpa_front #(
  parameter int FRACTION_BITS = 8
) (
  input  fpa_pkg::in_item_t request,
  output fpa_pkg::entry_t   entry
);

  logic signed [31:0] a;
  logic signed [31:0] b;
  logic signed [32:0] sum;
  logic signed [32:0] diff;
  logic signed [31:0] hi_a;
  logic               lt;
  fpa_pkg::out_item_t fast;

  assign a    = request.operand_a;
  assign b    = request.operand_b;
  assign sum  = {a[31], a} + {b[31], b};
  assign diff = {a[31], a} - {b[31], b};
  assign hi_a = a >>> (31 - FRACTION_BITS);
  assign lt   = a < b;

  always_comb begin
    fast = '0;
    entry.cls = fpa_pkg::CLS_FAST;
    unique case (request.opcode)
      fpa_pkg::OP_ADD: begin
        fast.overflow = sum[32] != sum[31];
        fast.result_value = fast.overflow ? (sum[32] ? fpa_pkg::RAW_MIN : fpa_pkg::RAW_MAX)
                                          : sum[31:0];
      end
      fpa_pkg::OP_SUB: begin
        fast.overflow = diff[32] != diff[31];
        fast.result_value = fast.overflow ? (diff[32] ? fpa_pkg::RAW_MIN : fpa_pkg::RAW_MAX)
                                          : diff[31:0];
      end
      fpa_pkg::OP_MUL: entry.cls = fpa_pkg::CLS_MUL;
      fpa_pkg::OP_DIV: begin
        if (b == 32'sd0) begin
          fast.divide_by_zero = 1'b1;
          if (a > 32'sd0) fast.result_value = fpa_pkg::RAW_MAX;
          else if (a < 32'sd0) fast.result_value = fpa_pkg::RAW_MIN;
        end else begin
          entry.cls = fpa_pkg::CLS_DIV;
        end
      end
      fpa_pkg::OP_LT: fast.compare_true = lt;
      fpa_pkg::OP_GT: fast.compare_true = !lt && (a != b);
      fpa_pkg::OP_LE: fast.compare_true = lt || (a == b);
      fpa_pkg::OP_GE: fast.compare_true = !lt;
      fpa_pkg::OP_EQ: fast.compare_true = a == b;
      fpa_pkg::OP_NE: fast.compare_true = a != b;
      fpa_pkg::OP_MIN: fast.result_value = lt ? a : b;
      fpa_pkg::OP_MAX: fast.result_value = (!lt && (a != b)) ? a : b;
      fpa_pkg::OP_ABS: begin
        fast.overflow = a == fpa_pkg::RAW_MIN;
        fast.result_value = fast.overflow ? fpa_pkg::RAW_MAX : (a[31] ? -a : a);
      end
      fpa_pkg::OP_INC: begin
        fast.overflow = a == fpa_pkg::RAW_MAX;
        fast.result_value = fast.overflow ? fpa_pkg::RAW_MAX : a + 32'sd1;
      end
      fpa_pkg::OP_DEC: begin
        fast.overflow = a == fpa_pkg::RAW_MIN;
        fast.result_value = fast.overflow ? fpa_pkg::RAW_MIN : a - 32'sd1;
      end
      fpa_pkg::OP_FROM_INT: begin
        fast.overflow = !((hi_a == 32'sd0) || (hi_a == -32'sd1));
        fast.result_value = fast.overflow ? (a[31] ? fpa_pkg::RAW_MIN : fpa_pkg::RAW_MAX)
                                          : (a <<< FRACTION_BITS);
      end
      fpa_pkg::OP_TO_INT: fast.result_value = a >>> FRACTION_BITS;
      default: fast = '0;
    endcase
    entry.fast  = fast;
    entry.mag_a = a[31] ? 32'(-a) : 32'(a);
    entry.mag_b = b[31] ? 32'(-b) : 32'(b);
    entry.neg   = a[31] ^ b[31];
  end

endmodule

### design/fpa_queue.sv
// Two-entry queue between the front end and the execution pipeline.
// Depends on fpa_pkg.
module fpa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  fpa_pkg::entry_t push_data,
  input  logic            pop,
  output fpa_pkg::entry_t head,
  output logic            not_empty,
  output logic            full
);

  fpa_pkg::entry_t mem [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      count;

  assign head      = mem[rptr];
  assign not_empty = count != 2'd0;
  assign full      = count == 2'd2;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop) rptr <= !rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

### design/fpa_back.sv
// Execution pipeline: a multiplier stage, a one-bit-per-stage divider,
// rounding and saturation. Depends on fpa_pkg.
module fpa_back #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  fpa_pkg::entry_t    in_entry,
  output logic               done,
  output fpa_pkg::out_item_t result
);

  localparam int NUM_W = 32 + FRACTION_BITS;
  localparam int NS    = NUM_W;
  localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

  logic               v    [NS + 1];
  fpa_pkg::op_class_t cls  [NS + 1];
  fpa_pkg::out_item_t fast [NS + 1];
  logic               neg  [NS + 1];
  logic [31:0]        rem  [NS + 1];
  logic [NUM_W-1:0]   nq   [NS + 1];
  logic [31:0]        den  [NS + 1];

  logic [63:0]        product;
  logic [31+NUM_W:0]  load;

  assign product = 64'(in_entry.mag_a) * 64'(in_entry.mag_b);
  assign load    = (32 + NUM_W)'(product);

  always_ff @(posedge clk) begin
    if (rst) v[0] <= 1'b0;
    else v[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    cls[0]  <= in_entry.cls;
    fast[0] <= in_entry.fast;
    neg[0]  <= in_entry.neg;
    den[0]  <= in_entry.mag_b;
    if (in_entry.cls == fpa_pkg::CLS_MUL) begin
      {rem[0], nq[0]} <= load;
    end else begin
      rem[0] <= '0;
      nq[0]  <= {in_entry.mag_a, FRACTION_BITS'(0)};
    end
  end

  for (genvar i = 1; i <= NS; i++) begin : g_step
    logic [32:0] trial;
    logic        ge;

    assign trial = {rem[i-1], nq[i-1][NUM_W-1]};
    assign ge    = trial >= {1'b0, den[i-1]};

    always_ff @(posedge clk) begin
      if (rst) v[i] <= 1'b0;
      else v[i] <= v[i-1];
    end

    always_ff @(posedge clk) begin
      cls[i]  <= cls[i-1];
      fast[i] <= fast[i-1];
      neg[i]  <= neg[i-1];
      den[i]  <= den[i-1];
      if (cls[i-1] == fpa_pkg::CLS_DIV) begin
        rem[i] <= ge ? 32'(trial - {1'b0, den[i-1]}) : trial[31:0];
        nq[i]  <= {nq[i-1][NUM_W-2:0], ge};
      end else begin
        rem[i] <= rem[i-1];
        nq[i]  <= nq[i-1];
      end
    end
  end

  logic               rv;
  fpa_pkg::op_class_t rcls;
  fpa_pkg::out_item_t rfast;
  logic               rneg;
  logic [63:0]        mq;
  logic [63:0]        mq_next;
  logic [63:0]        prod_last;
  logic               round_up;

  assign prod_last = 64'({rem[NS], nq[NS]});
  assign round_up  = {rem[NS], 1'b0} >= {1'b0, den[NS]};

  always_comb begin
    if (cls[NS] == fpa_pkg::CLS_MUL) mq_next = (prod_last + HALF) >> FRACTION_BITS;
    else mq_next = 64'(nq[NS]) + 64'(round_up);
  end

  always_ff @(posedge clk) begin
    if (rst) rv <= 1'b0;
    else rv <= v[NS];
  end

  always_ff @(posedge clk) begin
    rcls  <= cls[NS];
    rfast <= fast[NS];
    rneg  <= neg[NS];
    mq    <= mq_next;
  end

  fpa_pkg::out_item_t sat;

  always_comb begin
    sat = '0;
    if (rcls == fpa_pkg::CLS_FAST) begin
      sat = rfast;
    end else if (rneg) begin
      sat.overflow     = mq > 64'h8000_0000;
      sat.result_value = sat.overflow ? fpa_pkg::RAW_MIN : 32'(32'd0 - mq[31:0]);
    end else begin
      sat.overflow     = mq > 64'h7FFF_FFFF;
      sat.result_value = sat.overflow ? fpa_pkg::RAW_MAX : mq[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= rv;
  end

  always_ff @(posedge clk) begin
    result <= sat;
  end

endmodule

### design/fixed_point_alu_q24_8.sv
// Top level of the signed fixed-point ALU on 32-bit raw values.
// Depends on fpa_pkg, fpa_front, fpa_queue and fpa_back.
//
//   Channel   Handshake         Payload
//   request   start / busy      request (fpa_pkg::in_item_t)
//   result    done (strobe)     result  (fpa_pkg::out_item_t)
//
// One item is accepted per cycle while busy is low. Each item then passes
// through the queue, the multiplier and divider stages, rounding and the output.
// Results leave in the order the items came in, one per cycle at most.
// Reset clears the queue and all pipeline valid bits.
// The receiver cannot stall; busy rises only when the front queue is full.
module fixed_point_alu_q24_8 #(
  parameter int FRACTION_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  fpa_pkg::in_item_t  request,
  output logic               done,
  output fpa_pkg::out_item_t result
);

  fpa_pkg::entry_t entry;
  fpa_pkg::entry_t head;
  logic            not_empty;
  logic            full;

  assign busy = full;

  fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
    .request (request),
    .entry   (entry)
  );

  fpa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (start && !full),
    .push_data (entry),
    .pop       (not_empty),
    .head      (head),
    .not_empty (not_empty),
    .full      (full)
  );

  fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (not_empty),
    .in_entry (head),
    .done     (done),
    .result   (result)
  );

endmodule

### design/fpa_checker.sv
// Port-level checks of the fixed-point ALU, bound to its top level.
// Depends on fpa_pkg and fixed_point_alu_q24_8_defines.svh.
`include "fixed_point_alu_q24_8_defines.svh"

module fpa_checker (
  input logic               clk,
  input logic               rst,
  input logic               busy,
  input logic               done,
  input fpa_pkg::out_item_t result
);

  logic is_zero;
  logic at_limit;

  assign is_zero  = result.result_value == 32'sd0;
  assign at_limit = (result.result_value == fpa_pkg::RAW_MAX) ||
                    (result.result_value == fpa_pkg::RAW_MIN);

  `FPA_ASSERT_ALWAYS(a_no_done_after_reset, rst |=> !done)
  `FPA_ASSERT_ALWAYS(a_no_busy_after_reset, rst |=> !busy)
  `FPA_ASSERT(a_compare_clean, done && result.compare_true |-> is_zero && !result.overflow)
  `FPA_ASSERT(a_div_zero_clean, done && result.divide_by_zero |-> !result.overflow)
  `FPA_ASSERT(a_overflow_saturates, done && result.overflow |-> at_limit)

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (
  .clk     (clk),
  .rst     (rst),
  .busy    (busy),
  .done    (done),
  .result  (result)
);
